// ----- rtl/fba_pkg.sv -----
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types, constants and helpers of the fixed block allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int WORD_BYTES = 8;
    localparam int WB_SH      = $clog2(WORD_BYTES);
    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = 11;
    localparam int ADDR_W     = 32;
    localparam int PAYLOAD_W  = 16;
    localparam int STRIDE_W   = 17;
    localparam int PROD_W     = IDX_W + STRIDE_W;

    // control header plus worst alignment pad
    localparam logic [ADDR_W-1:0] OVERHEAD   = ADDR_W'(3 * WORD_BYTES - 1);
    localparam logic [CNT_W-1:0]  LINK_NULL  = CNT_W'(MAX_BLOCKS);
    localparam logic [ADDR_W-1:0] MAX_COUNT  = ADDR_W'(MAX_BLOCKS);

    localparam logic [1:0] REG_POOL_BASE     = 2'd0;
    localparam logic [1:0] REG_POOL_BYTES    = 2'd1;
    localparam logic [1:0] REG_PAYLOAD_BYTES = 2'd2;

    localparam logic       FUNC_ALLOC = 1'b0;
    localparam logic       FUNC_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] free_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [1:0]        status;
        logic [CNT_W-1:0]  free_count;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   dividend;
        logic [STRIDE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   quotient;
        logic [STRIDE_W-1:0] remainder;
    } div_res_t;

    // payload rounded up to a word, plus the block header
    function automatic logic [STRIDE_W-1:0] stride_of(input logic [PAYLOAD_W-1:0] p);
        logic [STRIDE_W-WB_SH-1:0] up;
        up = (STRIDE_W-WB_SH)'(p[PAYLOAD_W-1:WB_SH])
           + (STRIDE_W-WB_SH)'(p[WB_SH-1:0] != '0);
        return {up, {WB_SH{1'b0}}} + STRIDE_W'(WORD_BYTES);
    endfunction

    // payload address of block 0
    function automatic logic [ADDR_W-1:0] first_payload_of(input logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] aligned;
        aligned = (base + ADDR_W'(WORD_BYTES - 1)) & ~ADDR_W'(WORD_BYTES - 1);
        return aligned + ADDR_W'(3 * WORD_BYTES);
    endfunction

endpackage

// ----- rtl/fba_div.sv -----
// ----------------------------------------------------------------------------
// fba_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fba_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fba_pkg::div_req_t req,
    output logic             done,
    output fba_pkg::div_res_t res
);

    localparam int STEP_W = $clog2(fba_pkg::ADDR_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [fba_pkg::ADDR_W-1:0]    quo_reg;
    logic [fba_pkg::STRIDE_W-1:0]  rem_reg;
    logic [fba_pkg::STRIDE_W-1:0]  dvs_reg;
    logic [fba_pkg::STRIDE_W:0]    trial;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[fba_pkg::ADDR_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(fba_pkg::ADDR_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[fba_pkg::ADDR_W-2:0], fits};
            if (fits)
                rem_reg <= fba_pkg::STRIDE_W'(trial - {1'b0, dvs_reg});
            else
                rem_reg <= trial[fba_pkg::STRIDE_W-1:0];
        end
    end

    assign done          = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// ----- rtl/fixed_block_allocator.sv -----
// ----------------------------------------------------------------------------
// fixed_block_allocator
// Fixed-size block allocator with a LIFO free list held in a link memory.
//
//   channel   signals                            transfer when
//   command   start, busy, cmd                   start high and busy low
//   result    done, result                       done high (one cycle)
//   config    cfg_we, cfg_index, cfg_data        cfg_we high
//
// Allocation from the free list runs link read, multiply and add, from a
// fresh block multiply and add; an empty report comes straight from idle. A
// free waits on the 32-step divider that maps the address to a block index.
// A register write restarts the pool; block count runs on the same divider,
// busy high meanwhile. After reset the pool is empty and ready.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module fixed_block_allocator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fba_pkg::in_item_t    cmd,
    output logic                 done,
    output fba_pkg::out_item_t   result,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CINIT = 3'd1;
    localparam logic [2:0] S_CDIV  = 3'd2;
    localparam logic [2:0] S_LINK  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_ADDR  = 3'd5;
    localparam logic [2:0] S_FDIV  = 3'd6;

    localparam int AW = fba_pkg::ADDR_W;
    localparam int CW = fba_pkg::CNT_W;
    localparam int IW = fba_pkg::IDX_W;

    logic [2:0]                     state_reg, state_next;
    logic [AW-1:0]                  base_reg, base_next;
    logic [AW-1:0]                  bytes_reg, bytes_next;
    logic [fba_pkg::PAYLOAD_W-1:0]  payload_reg, payload_next;
    logic [AW-1:0]                  first_reg, first_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [CW-1:0]                  free_reg, free_next;
    logic [CW-1:0]                  head_reg, head_next;
    logic                           head_valid_reg, head_valid_next;
    logic [CW-1:0]                  fresh_reg, fresh_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [fba_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic                           done_reg, done_next;
    fba_pkg::out_item_t             result_reg, result_next;

    logic [CW-1:0]                  link_mem [0:fba_pkg::MAX_BLOCKS-1];
    logic [CW-1:0]                  rd_data_reg;
    logic                           mem_re;
    logic [IW-1:0]                  mem_raddr;
    logic                           mem_we;
    logic [IW-1:0]                  mem_waddr;
    logic [CW-1:0]                  mem_wdata;

    logic                           div_start;
    fba_pkg::div_req_t              div_req;
    logic                           div_done;
    fba_pkg::div_res_t              div_res;

    logic [fba_pkg::STRIDE_W-1:0]   stride;
    logic [AW-1:0]                  sat_count;
    logic                           bad_free;

    assign stride = fba_pkg::stride_of(payload_reg);

    fba_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .res   (div_res)
    );

    assign sat_count = (div_res.quotient > fba_pkg::MAX_COUNT) ? fba_pkg::MAX_COUNT
                                                               : div_res.quotient;

    assign bad_free = (div_res.remainder != '0)
                   || (div_res.quotient >= AW'(count_reg))
                   || (div_res.quotient >= AW'(fresh_reg))
                   || (free_reg >= count_reg);

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        bytes_next      = bytes_reg;
        payload_next    = payload_reg;
        first_next      = first_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        fresh_next      = fresh_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        mem_re          = 1'b0;
        mem_raddr       = head_reg[IW-1:0];
        mem_we          = 1'b0;
        mem_waddr       = div_res.quotient[IW-1:0];
        mem_wdata       = head_valid_reg ? head_reg : fba_pkg::LINK_NULL;
        div_start       = 1'b0;
        div_req.dividend = bytes_reg - fba_pkg::OVERHEAD;
        div_req.divisor  = stride;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.func == fba_pkg::FUNC_FREE)
                    begin
                        div_start        = 1'b1;
                        div_req.dividend = cmd.free_address - first_reg;
                        state_next       = S_FDIV;
                    end
                    else if (free_reg != '0 && head_valid_reg)
                    begin
                        mem_re     = 1'b1;
                        idx_next   = head_reg[IW-1:0];
                        state_next = S_LINK;
                    end
                    else if (free_reg != '0 && fresh_reg < count_reg)
                    begin
                        idx_next   = fresh_reg[IW-1:0];
                        fresh_next = fresh_reg + CW'(1);
                        state_next = S_MUL;
                    end
                    else
                    begin
                        done_next                 = 1'b1;
                        result_next.block_address = '0;
                        result_next.status        = fba_pkg::ST_EMPTY;
                        result_next.free_count    = free_reg;
                    end
                end
            end
            S_CINIT:
            begin
                first_next = fba_pkg::first_payload_of(base_reg);
                if (bytes_reg < fba_pkg::OVERHEAD)
                begin
                    count_next = '0;
                    free_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_CDIV;
                end
            end
            S_CDIV:
            begin
                if (div_done)
                begin
                    count_next = sat_count[CW-1:0];
                    free_next  = sat_count[CW-1:0];
                    state_next = S_IDLE;
                end
            end
            S_LINK:
            begin
                head_next       = rd_data_reg;
                head_valid_next = rd_data_reg != fba_pkg::LINK_NULL;
                state_next      = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = idx_reg * stride;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                free_next                 = free_reg - CW'(1);
                done_next                 = 1'b1;
                result_next.block_address = first_reg + AW'(prod_reg);
                result_next.status        = fba_pkg::ST_OK;
                result_next.free_count    = free_reg - CW'(1);
                state_next                = S_IDLE;
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    done_next                 = 1'b1;
                    result_next.block_address = '0;
                    state_next                = S_IDLE;
                    if (bad_free)
                    begin
                        result_next.status     = fba_pkg::ST_BAD_FREE;
                        result_next.free_count = free_reg;
                    end
                    else
                    begin
                        mem_we                 = 1'b1;
                        head_next              = CW'(div_res.quotient[IW-1:0]);
                        head_valid_next        = 1'b1;
                        free_next              = free_reg + CW'(1);
                        result_next.status     = fba_pkg::ST_OK;
                        result_next.free_count = free_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write restarts the pool
        if (cfg_we)
        begin
            case (cfg_index)
                fba_pkg::REG_POOL_BASE:
                begin
                    base_next       = cfg_data;
                    head_valid_next = 1'b0;
                    fresh_next      = '0;
                    state_next      = S_CINIT;
                end
                fba_pkg::REG_POOL_BYTES:
                begin
                    bytes_next      = cfg_data;
                    head_valid_next = 1'b0;
                    fresh_next      = '0;
                    state_next      = S_CINIT;
                end
                fba_pkg::REG_PAYLOAD_BYTES:
                begin
                    payload_next    = cfg_data[fba_pkg::PAYLOAD_W-1:0];
                    head_valid_next = 1'b0;
                    fresh_next      = '0;
                    state_next      = S_CINIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_reg       <= '0;
            bytes_reg      <= '0;
            payload_reg    <= fba_pkg::PAYLOAD_W'(8);
            first_reg      <= fba_pkg::first_payload_of('0);
            count_reg      <= '0;
            free_reg       <= '0;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            fresh_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            bytes_reg      <= bytes_next;
            payload_reg    <= payload_next;
            first_reg      <= first_next;
            count_reg      <= count_next;
            free_reg       <= free_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            fresh_reg      <= fresh_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    // link memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= link_mem[mem_raddr];
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
